// ===== hw/rtl/line_pixel_rasterizer_unit_macros.svh =====
// Assertion macros for the checker file lpr_checker.sv.
`ifndef LINE_PIXEL_RASTERIZER_UNIT_MACROS_SVH
`define LINE_PIXEL_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define LPR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rasterizer assertion failed");

// Next-cycle implication.
`define LPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rasterizer assertion failed");

`endif

// ===== hw/rtl/lpr_pkg.sv =====
package lpr_pkg;

  localparam int COORD_BITS = 8;
  localparam int COLOR_BITS = 5;
  localparam int STEP_BITS  = COORD_BITS + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;
  typedef logic [STEP_BITS-1:0]  steps_t;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic   cmd;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t color_index;
  } req_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last;
  } pix_t;

endpackage

// ===== hw/rtl/line_pixel_rasterizer_unit.sv =====
// Line rasterizer: turns two screen endpoints into a stream of pixels.
// Request channel (req_valid/req_ready/req): a beat with cmd = CMD_START loads
//   both endpoints and a color index and yields no pixel; a beat with
//   cmd = CMD_STEP yields the next pixel of the active line, or nothing if
//   no line is active. A start while a line is active drops that line.
// Pixel channel (pix_valid/pix_ready/pix): one beat per step, carrying x, y,
//   the held color index and last = 1 on the final pixel.
// Output: the pixel of an accepted step beat is loaded into the pixel
//   register, so it is visible on the port in the next cycle.
// Throughput: one request beat per cycle. The pixel register is taken and
//   refilled in the same cycle, so req_ready stays high while the receiver
//   keeps up; the per-cycle work is one add/compare on the minor-axis
//   accumulator and one increment of the major coordinate.
// Stall: while a pixel waits with pix_ready low, req_ready drops and the
//   pixel holds unchanged.
// Reset (rst, synchronous): no line active, pixel register empty.
module line_pixel_rasterizer_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lpr_pkg::req_t req,
  output logic          pix_valid,
  input  logic          pix_ready,
  output lpr_pkg::pix_t pix
);
  import lpr_pkg::*;

  // Line state
  logic   busy;
  logic   steep;
  logic   minor_down;
  logic   major_down;
  coord_t major_coord;
  coord_t minor_base;
  coord_t quotient;
  coord_t remainder;
  coord_t minor_span;
  coord_t major_span;
  steps_t steps_left;
  color_t color_held;

  logic accept;
  logic is_start;
  logic emit;

  // Setup of a new line
  logic   swap;
  coord_t x0, y0, x1, y1;
  coord_t dx, ady;
  logic   down;
  logic   vertical;
  logic   shallow;
  coord_t y_min;
  coord_t y_span;

  // Per-pixel datapath
  coord_t offset;
  coord_t minor;
  logic   fin;
  logic [COORD_BITS:0] rem_sum;
  logic                rem_wrap;
  logic [COORD_BITS:0] rem_diff;
  coord_t              remainder_next;

  assign req_ready = !pix_valid || pix_ready;
  assign accept    = req_valid && req_ready;
  assign is_start  = (req.cmd == CMD_START);
  assign emit      = accept && !is_start && busy;

  always_comb begin
    swap     = req.x_start > req.x_end;
    x0       = swap ? req.x_end   : req.x_start;
    y0       = swap ? req.y_end   : req.y_start;
    x1       = swap ? req.x_start : req.x_end;
    y1       = swap ? req.y_start : req.y_end;
    dx       = x1 - x0;
    down     = y1 < y0;
    ady      = down ? (y0 - y1) : (y1 - y0);
    shallow  = ady <= dx;
    vertical = req.x_start == req.x_end;
    y_min    = (req.y_start < req.y_end) ? req.y_start : req.y_end;
    y_span   = (req.y_start < req.y_end) ? (req.y_end - req.y_start)
                                         : (req.y_start - req.y_end);
  end

  always_comb begin
    // rounding toward floor when the minor axis runs downward
    offset   = quotient + COORD_BITS'(minor_down && (remainder != '0));
    minor    = minor_down ? (minor_base - offset) : (minor_base + offset);
    fin      = steps_left <= STEP_BITS'(1);
    rem_sum  = {1'b0, remainder} + {1'b0, minor_span};
    rem_wrap = rem_sum >= {1'b0, major_span};
    rem_diff = rem_sum - {1'b0, major_span};
    remainder_next = rem_wrap ? rem_diff[COORD_BITS-1:0] : rem_sum[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && is_start) begin
      busy <= 1'b1;  // every start has at least one pixel
    end else if (emit) begin
      busy <= !fin;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_start) begin
      color_held <= req.color_index;
      quotient   <= '0;
      remainder  <= '0;
      if (vertical) begin
        steep       <= 1'b1;
        minor_base  <= req.x_start;
        minor_down  <= 1'b0;
        major_down  <= 1'b0;
        major_coord <= y_min;
        minor_span  <= '0;
        major_span  <= COORD_BITS'(1);
        steps_left  <= {1'b0, y_span} + STEP_BITS'(1);
      end else if (shallow) begin
        steep       <= 1'b0;
        major_coord <= x0;
        major_down  <= 1'b0;
        minor_base  <= y0;
        minor_down  <= down;
        minor_span  <= ady;
        major_span  <= dx;
        steps_left  <= {1'b0, dx};
      end else begin
        steep       <= 1'b1;
        major_coord <= y0;
        major_down  <= down;
        minor_base  <= x0;
        minor_down  <= 1'b0;
        minor_span  <= dx;
        major_span  <= ady;
        steps_left  <= {1'b0, ady};
      end
    end else if (emit) begin
      major_coord <= major_down ? (major_coord - COORD_BITS'(1))
                                : (major_coord + COORD_BITS'(1));
      remainder   <= remainder_next;
      if (rem_wrap) begin
        quotient <= quotient + COORD_BITS'(1);
      end
      steps_left  <= fin ? '0 : (steps_left - STEP_BITS'(1));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (emit) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix.pixel_x     <= steep ? minor : major_coord;
      pix.pixel_y     <= steep ? major_coord : minor;
      pix.pixel_color <= color_held;
      pix.last        <= fin;
    end
  end

endmodule

// ===== hw/rtl/lpr_checker.sv =====
`include "line_pixel_rasterizer_unit_macros.svh"

module lpr_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input lpr_pkg::req_t req,
  input logic          pix_valid,
  input logic          pix_ready,
  input lpr_pkg::pix_t pix
);
  import lpr_pkg::*;

  logic pix_stall;
  logic start_beat;

  assign pix_stall  = pix_valid && !pix_ready;
  assign start_beat = req_valid && req_ready && (req.cmd == CMD_START);

  `LPR_ASSERT_NEXT(a_pix_hold, clk, rst, pix_stall, pix_valid)
  `LPR_ASSERT_NEXT(a_pix_stable, clk, rst, pix_stall, $stable(pix))
  // an empty output register never blocks the request side
  `LPR_ASSERT_NOW(a_ready_when_empty, clk, rst, !pix_valid, req_ready)
  // a start beat never produces a pixel
  `LPR_ASSERT_NEXT(a_start_silent, clk, rst, start_beat && !pix_stall, !pix_valid)

endmodule

bind line_pixel_rasterizer_unit lpr_checker u_lpr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .pix_valid (pix_valid),
  .pix_ready (pix_ready),
  .pix       (pix)
);

// ===== bench/tb.sv =====
// Bench for line_pixel_rasterizer_unit.
//
// Request beats go in one at a time through send_beat(). Each accepted beat
// also updates a behavioral copy of the rasterizer, which queues the pixel
// it should produce. An always block scores every accepted pixel beat
// against the oldest queued pixel, field by field.
//
// Sender gaps and receiver stalls come in random bursts. One phase holds
// the pixel side off for a long stretch so the unit fills and drops
// req_ready. The last phase runs at full rate on both sides.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpr_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  pix_valid;
  logic  pix_ready = 1'b0;
  pix_t  pix;

  line_pixel_rasterizer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix)
  );

  always #10 clk = ~clk;

  // Pixels still owed by the unit, oldest first.
  pix_t pixel_fifo[$];
  int   errors = 0;
  int   beats_sent = 0;

  // Knobs for random idling on each side.
  bit   sender_idles = 1'b1;
  bit   receiver_stalls = 1'b1;
  int   hold_requests = 0;

  // Shadow rasterizer state.
  logic   line_active = 1'b0;
  logic   steep_axis = 1'b0;
  logic   minor_dec = 1'b0;
  logic   major_dec = 1'b0;
  coord_t major_pos = '0;
  coord_t minor_origin = '0;
  coord_t quo = '0;
  coord_t rem = '0;
  coord_t minor_len = '0;
  coord_t major_len = '0;
  steps_t pixels_left = '0;
  color_t line_color = '0;

  // Apply one accepted request beat to the shadow state; a step on an
  // active line queues the pixel it must produce.
  task automatic rasterize(input req_t r);
    coord_t x0, y0, x1, y1, t, dx, ady, offset, minor;
    logic down, fin;
    int unsigned acc;
    pix_t p;
    if (r.cmd == CMD_START) begin
      line_color = r.color_index;
      x0 = r.x_start;
      y0 = r.y_start;
      x1 = r.x_end;
      y1 = r.y_end;
      quo = '0;
      rem = '0;
      if (x0 == x1) begin
        // vertical or single point: min row to max row, inclusive
        steep_axis   = 1'b1;
        minor_origin = x0;
        minor_dec    = 1'b0;
        major_dec    = 1'b0;
        major_pos    = (y0 < y1) ? y0 : y1;
        minor_len    = '0;
        major_len    = 8'd1;
        pixels_left  = steps_t'((y0 < y1) ? y1 - y0 : y0 - y1) + 1'b1;
      end else begin
        if (x0 > x1) begin
          t = x0; x0 = x1; x1 = t;
          t = y0; y0 = y1; y1 = t;
        end
        dx   = x1 - x0;
        down = (y1 < y0);
        ady  = down ? y0 - y1 : y1 - y0;
        if (ady <= dx) begin
          steep_axis   = 1'b0;
          major_pos    = x0;
          major_dec    = 1'b0;
          minor_origin = y0;
          minor_dec    = down;
          minor_len    = ady;
          major_len    = dx;
          pixels_left  = steps_t'(dx);
        end else begin
          steep_axis   = 1'b1;
          major_pos    = y0;
          major_dec    = down;
          minor_origin = x0;
          minor_dec    = 1'b0;
          minor_len    = dx;
          major_len    = ady;
          pixels_left  = steps_t'(ady);
        end
      end
      line_active = (pixels_left != 0);
    end else if (line_active) begin
      // a decreasing minor axis rounds toward the lower coordinate
      offset = quo + ((minor_dec && rem != 0) ? 8'd1 : 8'd0);
      minor  = minor_dec ? minor_origin - offset : minor_origin + offset;
      fin    = (pixels_left <= 1);
      p.pixel_x     = steep_axis ? minor : major_pos;
      p.pixel_y     = steep_axis ? major_pos : minor;
      p.pixel_color = line_color;
      p.last        = fin;
      pixel_fifo.push_back(p);
      major_pos = major_dec ? major_pos - 1'b1 : major_pos + 1'b1;
      acc = rem + minor_len;
      if (acc >= major_len) begin
        acc = acc - major_len;
        quo = quo + 1'b1;
      end
      rem = coord_t'(acc);
      pixels_left = fin ? '0 : pixels_left - 1'b1;
      line_active = !fin;
    end
  endtask

  // Offer one beat and hold it until accepted. Called at a rising edge;
  // returns at the edge of acceptance with req_valid still high.
  task automatic send_beat(input req_t r);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    rasterize(r);
    beats_sent++;
  endtask

  function automatic req_t start_req(input coord_t x0, y0, x1, y1, input color_t c);
    req_t r;
    r.cmd         = CMD_START;
    r.x_start     = x0;
    r.y_start     = y0;
    r.x_end       = x1;
    r.y_end       = y1;
    r.color_index = c;
    return r;
  endfunction

  // Step beat; the unused fields carry noise.
  function automatic req_t step_req();
    req_t r;
    r     = req_t'({$urandom, $urandom});
    r.cmd = CMD_STEP;
    return r;
  endfunction

  function automatic coord_t clamp_coord(input int v);
    return coord_t'((v < 0) ? 0 : (v > 255) ? 255 : v);
  endfunction

  // Pixel side: random stall bursts, plus a long hold on request from a test.
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= 120;
      pix_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pix_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pix_ready  <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 17);
      pix_ready  <= 1'b0;
    end else begin
      pix_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input int exp_v, got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Score each pixel beat against the oldest owed pixel.
  always @(posedge clk) begin
    pix_t want;
    if (!rst && pix_valid && pix_ready) begin
      if (pixel_fifo.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d c=%0d last=%0b",
                 $realtime, pix.pixel_x, pix.pixel_y, pix.pixel_color, pix.last);
        errors++;
      end else begin
        want = pixel_fifo.pop_front();
        check_field("pixel_x", want.pixel_x, pix.pixel_x);
        check_field("pixel_y", want.pixel_y, pix.pixel_y);
        check_field("pixel_color", want.pixel_color, pix.pixel_color);
        check_field("last", want.last, pix.last);
      end
    end
  end

  // Hand-picked lines near the screen edges, covering every line shape.
  task automatic test_directed();
    send_beat(step_req());                                  // step with no line
    send_beat(start_req(8'd255, 8'd255, 8'd255, 8'd255, 5'd31));  // single point
    send_beat(step_req());
    send_beat(step_req());                                  // line done, ignored
    send_beat(start_req(8'd0, 8'd2, 8'd0, 8'd0, 5'd0));     // vertical, given bottom-up
    repeat (3) send_beat(step_req());
    send_beat(start_req(8'd255, 8'd7, 8'd252, 8'd7, 5'd21)); // horizontal, reversed
    repeat (3) send_beat(step_req());
    send_beat(start_req(8'd0, 8'd255, 8'd4, 8'd253, 5'd10)); // shallow, rising row count down
    repeat (4) send_beat(step_req());
    send_beat(start_req(8'd0, 8'd0, 8'd255, 8'd255, 5'd31)); // long diagonal, cut short
    repeat (2) send_beat(step_req());
    send_beat(start_req(8'd0, 8'd9, 8'd2, 8'd5, 5'd0));     // steep, rows decreasing
    repeat (4) send_beat(step_req());
  endtask

  // Well-formed lines with random content: a start, then its steps. Some
  // lines are cut by a restart and some get extra steps after the end.
  // With vary_idles set, sender gaps are switched on and off at random.
  task automatic run_random_lines(input int count, input bit vary_idles);
    int stop, reach, shape, pixels, steps, ddx, ddy;
    coord_t x0, y0, x1, y1;
    stop = beats_sent + count;
    while (beats_sent < stop) begin
      if (vary_idles && $urandom_range(0, 15) == 0) sender_idles = $urandom_range(0, 1);
      shape = $urandom_range(0, 9);
      x0 = coord_t'($urandom);
      y0 = coord_t'($urandom);
      reach = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(1, 12);
      x1 = clamp_coord(int'(x0) + $urandom_range(0, 2 * reach) - reach);
      y1 = clamp_coord(int'(y0) + $urandom_range(0, 2 * reach) - reach);
      case (shape)
        0: begin x1 = x0; y1 = y0; end
        1: x1 = x0;
        2: y1 = y0;
        default: ;
      endcase
      ddx = (x1 > x0) ? x1 - x0 : x0 - x1;
      ddy = (y1 > y0) ? y1 - y0 : y0 - y1;
      pixels = (ddx == 0) ? ddy + 1 : (ddx > ddy ? ddx : ddy);
      steps = pixels;
      if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, pixels);
      else if ($urandom_range(0, 7) == 0) steps = pixels + $urandom_range(1, 3);
      send_beat(start_req(x0, y0, x1, y1, color_t'($urandom)));
      repeat (steps) send_beat(step_req());
    end
  endtask

  // Hold the pixel side off while a long line keeps streaming in, so the
  // unit backs up into the request side.
  task automatic test_stall_fill();
    sender_idles = 1'b0;
    hold_requests <= hold_requests + 1;
    send_beat(start_req(8'd20, 8'd100, 8'd90, 8'd130, 5'd17));
    repeat (70) send_beat(step_req());
    sender_idles = 1'b1;
  endtask

  // Unstructured beats: mostly steps, starts with endpoints anywhere.
  task automatic test_noise(input int count);
    req_t r;
    repeat (count) begin
      r = req_t'({$urandom, $urandom});
      r.cmd = ($urandom_range(0, 9) < 7) ? CMD_STEP : CMD_START;
      send_beat(r);
    end
  endtask

  task automatic test_full_rate(input int count);
    sender_idles = 1'b0;
    receiver_stalls <= 1'b0;
    run_random_lines(count, 1'b0);
  endtask

  initial begin
    int guard;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    run_random_lines(850, 1'b1);
    test_stall_fill();
    test_noise(150);
    test_full_rate(150);
    req_valid <= 1'b0;
    // drain, then give a late extra pixel time to show up
    guard = 0;
    while (pixel_fifo.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pixel_fifo.size() != 0) begin
      $display("%0t: missing pixels, expected %0d more, got none", $realtime,
               pixel_fifo.size());
      errors++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
